### rtl/abkf_pkg.sv
package abkf_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_COV = 28;
   localparam int CFG_WIDTH = 31;
   localparam int ADDR_WIDTH = 4;

   // register indexes, byte address is 4 * index
   localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
   localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
   localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
   localparam logic [1:0] REG_SAMPLE_DT   = 2'd3;

   typedef struct packed {
      logic signed [31:0] accel_angle;
      logic signed [31:0] gyro_rate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] fused_angle;
      logic signed [31:0] corrected_rate;
   } rsp_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] angle_process_noise;
      logic [CFG_WIDTH-1:0] bias_process_noise;
      logic [CFG_WIDTH-1:0] measure_noise;
      logic [CFG_WIDTH-1:0] sample_period;
   } cfg_type;

   // sequencer steps, in execution order
   localparam logic [4:0] S_BIASE = 5'd0;
   localparam logic [4:0] S_ANGP  = 5'd1;
   localparam logic [4:0] S_DAA1  = 5'd2;
   localparam logic [4:0] S_DAA2  = 5'd3;
   localparam logic [4:0] S_CAAP  = 5'd4;
   localparam logic [4:0] S_PB    = 5'd5;
   localparam logic [4:0] S_CABP  = 5'd6;
   localparam logic [4:0] S_CBBP  = 5'd7;
   localparam logic [4:0] S_ERR   = 5'd8;
   localparam logic [4:0] S_K0    = 5'd9;
   localparam logic [4:0] S_K1    = 5'd10;
   localparam logic [4:0] S_C1    = 5'd11;
   localparam logic [4:0] S_C2    = 5'd12;
   localparam logic [4:0] S_C3    = 5'd13;
   localparam logic [4:0] S_C4    = 5'd14;
   localparam logic [4:0] S_C5    = 5'd15;
   localparam logic [4:0] S_C6    = 5'd16;
   localparam logic [4:0] S_FIRST = S_BIASE;
   localparam logic [4:0] S_LAST  = S_C6;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_MUL = 2'd1;
   localparam logic [1:0] KIND_DIV = 2'd2;

   typedef struct packed {
      logic       load;
      logic       start;
      logic       wb;
      logic       out_load;
      logic [4:0] step;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
   } stat_type;

   function automatic logic [1:0] step_kind(input logic [4:0] step);
      case (step)
         S_BIASE, S_DAA1, S_DAA2, S_PB, S_ERR: step_kind = KIND_ADD;
         S_K0, S_K1: step_kind = KIND_DIV;
         default: step_kind = KIND_MUL;
      endcase
   endfunction

endpackage

### rtl/abkf_csr.sv
module abkf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [abkf_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output abkf_pkg::cfg_type               cfg
);

   abkf_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0] idx;

   assign idx = paddr[3:2];
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (idx)
            abkf_pkg::REG_ANGLE_NOISE:
               cfg_in.angle_process_noise = pwdata[abkf_pkg::CFG_WIDTH-1:0];
            abkf_pkg::REG_BIAS_NOISE:
               cfg_in.bias_process_noise = pwdata[abkf_pkg::CFG_WIDTH-1:0];
            abkf_pkg::REG_MEAS_NOISE:
               cfg_in.measure_noise = pwdata[abkf_pkg::CFG_WIDTH-1:0];
            abkf_pkg::REG_SAMPLE_DT:
               cfg_in.sample_period = pwdata[abkf_pkg::CFG_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         abkf_pkg::REG_ANGLE_NOISE: prdata = {1'b0, cfg_ff.angle_process_noise};
         abkf_pkg::REG_BIAS_NOISE: prdata = {1'b0, cfg_ff.bias_process_noise};
         abkf_pkg::REG_MEAS_NOISE: prdata = {1'b0, cfg_ff.measure_noise};
         abkf_pkg::REG_SAMPLE_DT: prdata = {1'b0, cfg_ff.sample_period};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_process_noise <= 31'd268435;
         cfg_ff.bias_process_noise <= 31'd805306;
         cfg_ff.measure_noise <= 31'd134217728;
         cfg_ff.sample_period <= 31'd5368709;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/abkf_ctrl.sv
module abkf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  abkf_pkg::stat_type  stat,
   output abkf_pkg::cmd_type   cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind;
   logic       advance;

   assign kind = abkf_pkg::step_kind(step_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      advance = 1'b0;
      cmd = '0;
      cmd.step = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in = abkf_pkg::S_FIRST;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (kind == abkf_pkg::KIND_ADD) begin
               cmd.wb = 1'b1;
               advance = 1'b1;
            end else begin
               cmd.start = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if ((kind == abkf_pkg::KIND_MUL && stat.mul_done) ||
                (kind == abkf_pkg::KIND_DIV && stat.div_done)) begin
               cmd.wb = 1'b1;
               advance = 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (advance) begin
         if (step_ff == abkf_pkg::S_LAST) begin
            state_in = ST_OUT;
         end else begin
            step_in = step_ff + 5'd1;
            state_in = ST_ISSUE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= abkf_pkg::S_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_start_pulse: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !cmd.start)
      else $error("unit start held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while a sample is in flight");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      (stat.mul_done || stat.div_done) |-> (state_ff == ST_WAIT))
      else $error("unit finished outside of wait state");

endmodule

### rtl/abkf_datapath.sv
module abkf_datapath #(
   parameter int DATA_WIDTH = abkf_pkg::DATA_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  abkf_pkg::cmd_type   cmd,
   input  abkf_pkg::cfg_type   cfg,
   input  abkf_pkg::req_type   req_data,
   output abkf_pkg::stat_type  stat,
   output abkf_pkg::rsp_type   rsp_data
);

   localparam int W = DATA_WIDTH;
   localparam int OW = (W > 32) ? W : 32;
   localparam int ND = (OW + 15) / 16;
   localparam int MBW = ND * 16;
   localparam int AW = OW + MBW + 1;
   localparam int MCW = $clog2(ND);
   localparam int DV = W + abkf_pkg::FRAC_COV;
   localparam int DCW = $clog2(DV);

   localparam logic signed [OW:0] SMAXX = $signed({{(OW - W + 2){1'b0}}, {(W - 1){1'b1}}});
   localparam logic signed [OW:0] SMINX = ~SMAXX;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W - 1){1'b0}}};
   localparam logic signed [W-1:0] ONE_W = (W > 29) ? (W'(1) << abkf_pkg::FRAC_COV) : WMAX;
   localparam logic signed [OW:0] L32MAX = (OW + 1)'(33'sh07FFFFFFF);
   localparam logic signed [OW:0] L32MIN = ~L32MAX;
   localparam logic [AW-1:0] RND = AW'(1) << (abkf_pkg::FRAC_COV - 1);
   localparam logic [AW-1:0] MLIMP = AW'({(W - 1){1'b1}});
   localparam logic [AW-1:0] MLIMN = MLIMP + AW'(1);
   localparam logic [DV-1:0] DLIMP = DV'({(W - 1){1'b1}});
   localparam logic [DV-1:0] DLIMN = DLIMP + DV'(1);

   function automatic logic signed [W-1:0] sat_w(input logic signed [OW:0] v);
      if (v > SMAXX) sat_w = WMAX;
      else if (v < SMINX) sat_w = WMIN;
      else sat_w = v[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] add_sat(input logic signed [OW-1:0] a,
                                                  input logic signed [OW-1:0] b,
                                                  input logic sub);
      logic signed [OW:0] ax;
      logic signed [OW:0] bx;
      ax = a;
      bx = b;
      add_sat = sat_w(sub ? ax - bx : ax + bx);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [OW:0] v);
      if (v > L32MAX) sat32 = 32'sh7FFFFFFF;
      else if (v < L32MIN) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction

   function automatic logic [OW-1:0] mag_of(input logic signed [OW-1:0] v);
      mag_of = v[OW-1] ? (~v + 1'b1) : v;
   endfunction

   // filter state and step scratch
   logic signed [W-1:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [W-1:0] caa_ff, caa_in, cab_ff, cab_in, cba_ff, cba_in, cbb_ff, cbb_in;
   logic signed [W-1:0] tmp_ff, tmp_in, err_ff, err_in, den_ff, den_in;
   logic signed [W-1:0] k0_ff, k0_in, k1_ff, k1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic signed [31:0]  gyro_ff, accel_ff;
   abkf_pkg::rsp_type   rsp_ff;

   logic signed [OW-1:0] ang_x, bias_x, caa_x, cab_x, cba_x, cbb_x, tmp_x;
   logic signed [OW-1:0] err_x, k0_x, k1_x, t0_x, t1_x;
   logic signed [OW-1:0] gyro_x, accel_x, apn_x, bpn_x, mn_x, dt_x, mres_x;

   assign ang_x = ang_ff;
   assign bias_x = bias_ff;
   assign caa_x = caa_ff;
   assign cab_x = cab_ff;
   assign cba_x = cba_ff;
   assign cbb_x = cbb_ff;
   assign tmp_x = tmp_ff;
   assign err_x = err_ff;
   assign k0_x = k0_ff;
   assign k1_x = k1_ff;
   assign t0_x = t0_ff;
   assign t1_x = t1_ff;
   assign gyro_x = gyro_ff;
   assign accel_x = accel_ff;
   assign apn_x = signed'(OW'(cfg.angle_process_noise));
   assign bpn_x = signed'(OW'(cfg.bias_process_noise));
   assign mn_x = signed'(OW'(cfg.measure_noise));
   assign dt_x = signed'(OW'(cfg.sample_period));

   // shared multiplier: 16-bit digit of the second operand per cycle
   logic [OW-1:0]   ma_ff;
   logic [MBW-1:0]  mb_ff;
   logic            mneg_ff, mbusy_ff, mdone_ff;
   logic [MCW-1:0]  mcnt_ff;
   logic [AW-1:0]   acc_ff;
   logic signed [OW-1:0] opa, opb;
   logic [15:0]     digit;
   logic [OW+15:0]  pp;
   logic [MCW+3:0]  shamt;
   logic [AW-1:0]   msh, mcl;
   logic signed [W-1:0] mres;

   always_comb begin
      case (cmd.step)
         abkf_pkg::S_CBBP: begin opa = bpn_x; opb = dt_x; end
         abkf_pkg::S_C1: begin opa = t0_x; opb = k0_x; end
         abkf_pkg::S_C2: begin opa = t1_x; opb = k0_x; end
         abkf_pkg::S_C3: begin opa = t0_x; opb = k1_x; end
         abkf_pkg::S_C4: begin opa = t1_x; opb = k1_x; end
         abkf_pkg::S_C5: begin opa = err_x; opb = k0_x; end
         abkf_pkg::S_C6: begin opa = err_x; opb = k1_x; end
         default: begin opa = tmp_x; opb = dt_x; end
      endcase
   end

   assign digit = mb_ff[16*mcnt_ff +: 16];
   assign pp = ma_ff * digit;
   assign shamt = {mcnt_ff, 4'b0000};
   assign msh = (acc_ff + RND) >> abkf_pkg::FRAC_COV;
   assign mcl = (msh > (mneg_ff ? MLIMN : MLIMP)) ? (mneg_ff ? MLIMN : MLIMP) : msh;
   assign mres = mneg_ff ? (~mcl[W-1:0] + 1'b1) : mcl[W-1:0];
   assign mres_x = mres;

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
      end else begin
         mdone_ff <= 1'b0;
         if (cmd.start && abkf_pkg::step_kind(cmd.step) == abkf_pkg::KIND_MUL) begin
            mbusy_ff <= 1'b1;
         end else if (mbusy_ff && mcnt_ff == MCW'(ND - 1)) begin
            mbusy_ff <= 1'b0;
            mdone_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ma_ff <= mag_of(opa);
         mb_ff <= MBW'(mag_of(opb));
         mneg_ff <= opa[OW-1] ^ opb[OW-1];
         acc_ff <= '0;
         mcnt_ff <= '0;
      end else if (mbusy_ff) begin
         acc_ff <= acc_ff + (AW'(pp) << shamt);
         mcnt_ff <= mcnt_ff + MCW'(1);
      end
   end

   // gain divider: restoring, one quotient bit per cycle
   logic [DV-1:0]  dvd_ff, quo_ff, dcl;
   logic [W-1:0]   rem_ff;
   logic [W:0]     rtrial, rdiff;
   logic           dneg_ff, dbusy_ff, ddone_ff, qbit;
   logic [DCW-1:0] dcnt_ff;
   logic signed [W-1:0] num, dres;
   logic [OW-1:0]  nmag;

   assign num = (cmd.step == abkf_pkg::S_K1) ? cba_ff : caa_ff;
   assign nmag = mag_of(OW'(num));
   assign rtrial = {rem_ff, dvd_ff[DV-1]};
   assign rdiff = rtrial - {1'b0, den_ff};
   assign qbit = (rtrial >= {1'b0, den_ff});
   assign dcl = (quo_ff > (dneg_ff ? DLIMN : DLIMP)) ? (dneg_ff ? DLIMN : DLIMP) : quo_ff;
   assign dres = dneg_ff ? (~dcl[W-1:0] + 1'b1) : dcl[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         if (cmd.start && abkf_pkg::step_kind(cmd.step) == abkf_pkg::KIND_DIV) begin
            if (den_ff > 0) dbusy_ff <= 1'b1;
            else ddone_ff <= 1'b1;
         end else if (dbusy_ff && dcnt_ff == DCW'(DV - 1)) begin
            dbusy_ff <= 1'b0;
            ddone_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dvd_ff <= {nmag[W-1:0], {abkf_pkg::FRAC_COV{1'b0}}};
         rem_ff <= '0;
         quo_ff <= '0;
         dcnt_ff <= '0;
         dneg_ff <= num[W-1];
      end else if (dbusy_ff) begin
         dvd_ff <= {dvd_ff[DV-2:0], 1'b0};
         rem_ff <= qbit ? rdiff[W-1:0] : rtrial[W-1:0];
         quo_ff <= {quo_ff[DV-2:0], qbit};
         dcnt_ff <= dcnt_ff + DCW'(1);
      end
   end

   assign stat.mul_done = mdone_ff;
   assign stat.div_done = ddone_ff;

   // step write-back
   always_comb begin
      ang_in = ang_ff; bias_in = bias_ff;
      caa_in = caa_ff; cab_in = cab_ff; cba_in = cba_ff; cbb_in = cbb_ff;
      tmp_in = tmp_ff; err_in = err_ff; den_in = den_ff;
      k0_in = k0_ff; k1_in = k1_ff; t0_in = t0_ff; t1_in = t1_ff;
      if (cmd.wb) begin
         case (cmd.step)
            abkf_pkg::S_BIASE: tmp_in = add_sat(gyro_x, bias_x, 1'b1);
            abkf_pkg::S_ANGP: ang_in = add_sat(ang_x, mres_x, 1'b0);
            abkf_pkg::S_DAA1: tmp_in = add_sat(apn_x, cab_x, 1'b1);
            abkf_pkg::S_DAA2: tmp_in = add_sat(tmp_x, cba_x, 1'b1);
            abkf_pkg::S_CAAP: caa_in = add_sat(caa_x, mres_x, 1'b0);
            abkf_pkg::S_PB: tmp_in = add_sat('0, cbb_x, 1'b1);
            abkf_pkg::S_CABP: begin
               cab_in = add_sat(cab_x, mres_x, 1'b0);
               cba_in = add_sat(cba_x, mres_x, 1'b0);
            end
            abkf_pkg::S_CBBP: cbb_in = add_sat(cbb_x, mres_x, 1'b0);
            abkf_pkg::S_ERR: begin
               err_in = add_sat(accel_x, ang_x, 1'b1);
               den_in = add_sat(mn_x, caa_x, 1'b0);
               t0_in = caa_ff;
               t1_in = cab_ff;
            end
            abkf_pkg::S_K0: k0_in = dres;
            abkf_pkg::S_K1: k1_in = dres;
            abkf_pkg::S_C1: caa_in = add_sat(caa_x, mres_x, 1'b1);
            abkf_pkg::S_C2: cab_in = add_sat(cab_x, mres_x, 1'b1);
            abkf_pkg::S_C3: cba_in = add_sat(cba_x, mres_x, 1'b1);
            abkf_pkg::S_C4: cbb_in = add_sat(cbb_x, mres_x, 1'b1);
            abkf_pkg::S_C5: ang_in = add_sat(ang_x, mres_x, 1'b0);
            abkf_pkg::S_C6: bias_in = add_sat(bias_x, mres_x, 1'b0);
            default: tmp_in = tmp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff <= '0;
         bias_ff <= '0;
         caa_ff <= ONE_W;
         cab_ff <= '0;
         cba_ff <= '0;
         cbb_ff <= ONE_W;
      end else begin
         ang_ff <= ang_in;
         bias_ff <= bias_in;
         caa_ff <= caa_in;
         cab_ff <= cab_in;
         cba_ff <= cba_in;
         cbb_ff <= cbb_in;
      end
   end

   always_ff @(posedge clock) begin
      tmp_ff <= tmp_in;
      err_ff <= err_in;
      den_ff <= den_in;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      if (cmd.load) begin
         gyro_ff <= req_data.gyro_rate;
         accel_ff <= req_data.accel_angle;
      end
      if (cmd.out_load) begin
         rsp_ff.fused_angle <= sat32((OW + 1)'(ang_x));
         rsp_ff.corrected_rate <= sat32((OW + 1)'(gyro_x) - (OW + 1)'(bias_x));
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### rtl/angle_bias_kalman_filter.sv
// two-state tilt angle / gyro bias kalman filter
//
// req channel: one word per imu sample (accel tilt angle and gyro rate, q16.16)
// rsp channel: one word per sample (fused angle and bias-corrected rate, q16.16)
// csr port: apb-style, registers at byte 0x0 angle noise, 0x4 bias noise,
//   0x8 measurement noise, 0xc sample period (all q3.28, 31 bits); pready tied high
//
// each sample runs an accept, 5 add steps, 10 multiply steps, 2 divide steps and an
// output; a multiply works through nd = ceil(max(DATA_WIDTH,32)/16) digits and a
// divide through DATA_WIDTH + 28 quotient bits
// the two gain divisions (one quotient bit per cycle) dominate, followed by the
// shared multiplier taking one 16-bit digit per cycle
// one sample is in flight at a time; req_ready is high only when the sequencer is idle
// a finished word sits in the output register; if the receiver stalls, the next
// sample may be taken and processed, and its result waits until the register frees
// reset (synchronous) clears angle and bias, sets both diagonal covariances to one,
// and restores the default noise and period registers
module angle_bias_kalman_filter #(
   parameter int DATA_WIDTH = abkf_pkg::DATA_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  abkf_pkg::req_type               req_data,
   // filtered output
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output abkf_pkg::rsp_type               rsp_data,
   // configuration
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [abkf_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   abkf_pkg::cfg_type  cfg;
   abkf_pkg::cmd_type  cmd;
   abkf_pkg::stat_type stat;

   // noise and period registers
   abkf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // step sequencer and handshakes
   abkf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // filter state, shared multiplier, gain divider, output register
   abkf_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

### tb/sv/angle_bias_kalman_filter_tb.sv
`timescale 1ns / 1ps

module angle_bias_kalman_filter_tb;

   localparam int  DW     = abkf_pkg::DATA_WIDTH_DEF;
   localparam int  FRAC_A = 16;
   localparam int  FRAC_C = abkf_pkg::FRAC_COV;
   localparam int  AWID   = abkf_pkg::ADDR_WIDTH;
   localparam longint VMAX = (64'sd1 <<< (DW - 1)) - 1;
   localparam longint VMIN = -VMAX - 1;
   localparam int  HOLDOFF_CYCLES = 3000;

   // filter predictor and store of expected output words
   class filter_scoreboard;
      longint angle_noise, bias_noise, meas_noise, dt;
      longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;
      abkf_pkg::rsp_type expected_words[$];
      int mismatches;

      function new();
         angle_noise = 268435;
         bias_noise  = 805306;
         meas_noise  = 134217728;
         dt          = 5368709;
         angle_est   = 0;
         bias_est    = 0;
         p_aa        = clamp(64'sd1 <<< FRAC_C);
         p_ab        = 0;
         p_ba        = 0;
         p_bb        = clamp(64'sd1 <<< FRAC_C);
         mismatches  = 0;
      endfunction

      function longint clamp(longint x);
         if (x > VMAX) return VMAX;
         if (x < VMIN) return VMIN;
         return x;
      endfunction

      // signed value from sign and magnitude, saturated to the data width
      function longint signed_sat(bit neg, logic [127:0] m);
         logic [127:0] lim;
         lim = neg ? 128'(VMAX) + 1 : 128'(VMAX);
         if (m > lim) m = lim;
         return neg ? -longint'(m) : longint'(m);
      endfunction

      // (a * b) >> sh, rounded half away from zero
      function longint fixed_mul(longint a, longint b, int sh);
         logic [127:0] ma, mb, p;
         ma = 128'(a < 0 ? -a : a);
         mb = 128'(b < 0 ? -b : b);
         p  = (ma * mb + (128'd1 << (sh - 1))) >> sh;
         return signed_sat((a < 0) != (b < 0), p);
      endfunction

      // n * 2^28 / d, truncated toward zero
      function longint gain_div(longint n, longint d);
         logic [127:0] mn;
         mn = 128'(n < 0 ? -n : n);
         return signed_sat(n < 0, (mn << FRAC_C) / 128'(d));
      endfunction

      function longint to_word(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function void set_reg(int idx, logic [31:0] value);
         longint v;
         v = longint'(value[30:0]);
         case (idx)
            abkf_pkg::REG_ANGLE_NOISE: angle_noise = v;
            abkf_pkg::REG_BIAS_NOISE:  bias_noise  = v;
            abkf_pkg::REG_MEAS_NOISE:  meas_noise  = v;
            abkf_pkg::REG_SAMPLE_DT:   dt          = v;
            default: ;
         endcase
      endfunction

      // one accepted sample: run the filter step and queue its output word
      function void note_sample(abkf_pkg::req_type s);
         longint accel, gyro, d_aa, pb, err, den, k0, k1, t0, t1;
         abkf_pkg::rsp_type w;
         accel = longint'(s.accel_angle);
         gyro  = longint'(s.gyro_rate);
         k0 = 0;
         k1 = 0;
         // predict
         angle_est = clamp(angle_est + fixed_mul(clamp(gyro - bias_est), dt, FRAC_C));
         d_aa = clamp(clamp(angle_noise - p_ab) - p_ba);
         pb   = clamp(-p_bb);
         p_aa = clamp(p_aa + fixed_mul(d_aa, dt, FRAC_C));
         p_ab = clamp(p_ab + fixed_mul(pb, dt, FRAC_C));
         p_ba = clamp(p_ba + fixed_mul(pb, dt, FRAC_C));
         p_bb = clamp(p_bb + fixed_mul(bias_noise, dt, FRAC_C));
         // gain, zero when the denominator is not positive
         err = clamp(accel - angle_est);
         den = clamp(meas_noise + p_aa);
         if (den > 0) begin
            k0 = gain_div(p_aa, den);
            k1 = gain_div(p_ba, den);
         end
         // correct
         t0 = p_aa;
         t1 = p_ab;
         p_aa = clamp(p_aa - fixed_mul(t0, k0, FRAC_C));
         p_ab = clamp(p_ab - fixed_mul(t1, k0, FRAC_C));
         p_ba = clamp(p_ba - fixed_mul(t0, k1, FRAC_C));
         p_bb = clamp(p_bb - fixed_mul(t1, k1, FRAC_C));
         angle_est = clamp(angle_est + fixed_mul(err, k0, FRAC_C));
         bias_est  = clamp(bias_est + fixed_mul(err, k1, FRAC_C));
         w.fused_angle    = 32'(to_word(angle_est));
         w.corrected_rate = 32'(to_word(gyro - bias_est));
         expected_words.push_back(w);
      endfunction

      function void check_word(abkf_pkg::rsp_type got);
         abkf_pkg::rsp_type exp_w;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected output word %h", got);
            return;
         end
         exp_w = expected_words.pop_front();
         if (got.fused_angle !== exp_w.fused_angle
               || got.corrected_rate !== exp_w.corrected_rate) begin
            mismatches++;
            if (mismatches <= 10)
               $display("word mismatch: angle exp %h got %h, rate exp %h got %h",
                        exp_w.fused_angle, got.fused_angle,
                        exp_w.corrected_rate, got.corrected_rate);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   abkf_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   abkf_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [AWID-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   filter_scoreboard sb = new();
   bit no_idle = 1'b0;       // when set, neither side inserts gaps
   bit hold_request = 1'b0;  // asks the receiver for one long stall

   angle_bias_kalman_filter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // watch both channels at the rising edge; inputs only move on the falling edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_sample(req_data);
         if (rsp_valid && rsp_ready) sb.check_word(rsp_data);
      end
   end

   // receiver: random stall per word, plus one long hold-off on request
   initial begin
      int wait_cycles;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         wait_cycles = no_idle ? 0 : $urandom_range(0, 19);
         if (hold_request) begin
            wait_cycles = HOLDOFF_CYCLES;
            hold_request = 1'b0;
         end
         if (wait_cycles > 0) begin
            rsp_ready = 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // register write: setup cycle then access cycle
   task automatic csr_write(int idx, logic [31:0] value);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = AWID'(4 * idx);
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      sb.set_reg(idx, value);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic send_sample(logic [31:0] accel, logic [31:0] gyro);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.accel_angle = accel;
      req_data.gyro_rate = gyro;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // sender pauses until every queued word has come back
   task automatic drain();
      req_valid = 1'b0;
      while (sb.expected_words.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // mostly plausible tilt/rate pairs, some full-range noise
   task automatic random_samples(int count);
      logic [31:0] a, g;
      repeat (count) begin
         if ($urandom_range(0, 9) < 7) begin
            a = 32'($signed($urandom_range(0, 180 << FRAC_A)) - (90 <<< FRAC_A));
            g = 32'($signed($urandom_range(0, 1000 << FRAC_A)) - (500 <<< FRAC_A));
         end else begin
            a = $urandom();
            g = $urandom();
         end
         send_sample(a, g);
      end
   endtask

   initial begin
      logic [31:0] corners[6];
      corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                  32'h0001_0000, 32'hffff_0000};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners at reset settings
      foreach (corners[i]) send_sample(corners[i], corners[5 - i]);
      send_sample(32'h7fff_ffff, 32'h7fff_ffff);
      send_sample(32'h8000_0000, 32'h8000_0000);
      send_sample(32'h0, 32'h0);
      drain();

      // largest settings, long receiver stall so the block backs up
      csr_write(abkf_pkg::REG_ANGLE_NOISE, 32'h7fff_ffff);
      csr_write(abkf_pkg::REG_BIAS_NOISE, 32'h7fff_ffff);
      csr_write(abkf_pkg::REG_MEAS_NOISE, 32'h7fff_ffff);
      csr_write(abkf_pkg::REG_SAMPLE_DT, 32'h7fff_ffff);
      foreach (corners[i]) send_sample(corners[i], corners[i]);
      hold_request = 1'b1;
      random_samples(180);
      drain();

      // smallest settings
      csr_write(abkf_pkg::REG_ANGLE_NOISE, 32'h0);
      csr_write(abkf_pkg::REG_BIAS_NOISE, 32'h0);
      csr_write(abkf_pkg::REG_MEAS_NOISE, 32'h1);
      csr_write(abkf_pkg::REG_SAMPLE_DT, 32'h1);
      foreach (corners[i]) send_sample(corners[5 - i], corners[i]);
      random_samples(180);
      drain();

      // back-to-back stretch with random settings
      no_idle = 1'b1;
      csr_write(abkf_pkg::REG_ANGLE_NOISE, $urandom());
      csr_write(abkf_pkg::REG_BIAS_NOISE, $urandom());
      csr_write(abkf_pkg::REG_MEAS_NOISE, 32'($urandom_range(1, 32'h7fff_ffff)));
      csr_write(abkf_pkg::REG_SAMPLE_DT, 32'($urandom_range(1, 32'h7fff_ffff)));
      random_samples(200);
      no_idle = 1'b0;
      drain();

      // several random settings, then the defaults again
      repeat (3) begin
         csr_write(abkf_pkg::REG_ANGLE_NOISE, 32'($urandom_range(0, 1 << 24)));
         csr_write(abkf_pkg::REG_BIAS_NOISE, 32'($urandom_range(0, 1 << 24)));
         csr_write(abkf_pkg::REG_MEAS_NOISE, 32'($urandom_range(1, 1 << 30)));
         csr_write(abkf_pkg::REG_SAMPLE_DT, 32'($urandom_range(1, 1 << 26)));
         random_samples(150);
         drain();
      end
      csr_write(abkf_pkg::REG_ANGLE_NOISE, 32'd268435);
      csr_write(abkf_pkg::REG_BIAS_NOISE, 32'd805306);
      csr_write(abkf_pkg::REG_MEAS_NOISE, 32'd134217728);
      csr_write(abkf_pkg::REG_SAMPLE_DT, 32'd5368709);
      random_samples(120);
      drain();

      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #40ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
